/* rtl/core/butq_pkg.sv */
package butq_pkg;

  localparam int QUEUE_DEPTH_DEF = 512;

  localparam logic [1:0] KIND_PUT = 2'd0;
  localparam logic [1:0] KIND_GET = 2'd1;
  localparam logic [1:0] KIND_TXE = 2'd2;
  localparam logic [1:0] KIND_RX  = 2'd3;

  localparam logic [7:0] LINE_FEED  = 8'h0A;
  localparam logic [7:0] CAR_RETURN = 8'h0D;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic [7:0] data;
  } butq_cmd_t;

endpackage

/* rtl/core/butq_ram.sv */
module butq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/butq_queue.sv */
module butq_queue import butq_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  butq_cmd_t     cmd,
  output logic [CW-1:0] count,
  output logic [7:0]    rd_data
);

  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (cmd.push) begin
      tail_nxt  = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
      count_nxt = count_r + CW'(1);
    end else if (cmd.pop) begin
      head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  butq_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (cmd.push),
    .wr_addr(tail_r),
    .wr_data(cmd.data),
    .rd_en  (cmd.pop),
    .rd_addr(head_r),
    .rd_data(rd_data)
  );

  assign count = count_r;

endmodule

/* rtl/core/buffered_uart_tx_rx_queues.sv */
// Buffered serial transmit and receive queues.
// The input channel carries one request per item: a put of a byte, a get,
// a transmitter-empty event or a received word. The result channel returns
// exactly one result per request, in order.
// A put of a line feed also queues a carriage return. A put with the
// transmitter idle, and a transmitter-empty event, send the head of the
// send queue with the stop bit set. A full send queue refuses a put whole;
// a full receive queue drops the received byte.
// Each queue keeps its bytes in a single-port-per-direction RAM with a
// registered read, and its head, tail and count in registers.
// A received word, or a put that queues at most one byte and sends nothing,
// loads its result straight from the idle state. A line feed put that queues
// its pair passes through a carriage-return state first. A put that sends, a
// get or a transmitter event then passes through a pop state, which loads a
// result with no byte if its queue is empty and else moves on to a data
// state that loads the byte from the registered RAM read.
// One request is in work at a time; the next is taken once the result has
// been taken, so no new request is taken before the last one is through.
// Reset empties both queues and clears the pending result.
// While the result channel stalls, the result is held and in_stall is high.
module buffered_uart_tx_rx_queues import butq_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_put_byte,
  input  logic        in_tx_idle,
  input  logic [15:0] in_rx_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_tx_valid,
  output logic [8:0]  out_tx_word,
  output logic        out_get_valid,
  output logic [7:0]  out_get_byte,
  output logic        out_put_refused,
  output logic        out_rx_dropped
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CR   = 2'd1;
  localparam logic [1:0] ST_POP  = 2'd2;
  localparam logic [1:0] ST_DATA = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    kind_r;
  logic          idle_r;
  logic          flag_r;
  logic          out_vld_r, out_vld_nxt;
  logic          txv_r;
  logic [8:0]    txw_r;
  logic          getv_r;
  logic [7:0]    getb_r;
  logic          ref_r;
  logic          drop_r;

  butq_cmd_t     snd_cmd, rcv_cmd;
  logic [CW-1:0] snd_cnt, rcv_cnt;
  logic [7:0]    snd_rdata, rcv_rdata;

  logic          in_acc;
  logic          put_lf;
  logic          put_ref;
  logic          ld, ld_txv, ld_getv, ld_ref, ld_drop;
  logic [7:0]    ld_b;

  assign in_acc  = in_valid && !in_stall;
  assign put_lf  = (in_put_byte == LINE_FEED);
  assign put_ref = put_lf ? ({1'b0, snd_cnt} + (CW + 1)'(2) > (CW + 1)'(QUEUE_DEPTH))
                          : (snd_cnt == CW'(QUEUE_DEPTH));

  always_comb begin
    state_nxt = state_r;
    snd_cmd   = '0;
    rcv_cmd   = '0;
    ld        = 1'b0;
    ld_txv    = 1'b0;
    ld_getv   = 1'b0;
    ld_b      = 8'h00;
    ld_ref    = 1'b0;
    ld_drop   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_kind)
            KIND_PUT: begin
              if (!put_ref) begin
                snd_cmd.push = 1'b1;
                snd_cmd.data = in_put_byte;
              end
              if (!put_ref && put_lf) begin
                state_nxt = ST_CR;
              end else if (in_tx_idle) begin
                state_nxt = ST_POP;
              end else begin
                ld     = 1'b1;
                ld_ref = put_ref;
              end
            end
            KIND_GET, KIND_TXE: begin
              state_nxt = ST_POP;
            end
            KIND_RX: begin
              ld = 1'b1;
              if (rcv_cnt == CW'(QUEUE_DEPTH)) begin
                ld_drop = 1'b1;
              end else begin
                rcv_cmd.push = 1'b1;
                rcv_cmd.data = in_rx_word[7:0];
              end
            end
            default: ;
          endcase
        end
      end
      ST_CR: begin
        snd_cmd.push = 1'b1;
        snd_cmd.data = CAR_RETURN;
        if (idle_r) begin
          state_nxt = ST_POP;
        end else begin
          ld        = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_POP: begin
        if (kind_r == KIND_GET) begin
          if (rcv_cnt != '0) begin
            rcv_cmd.pop = 1'b1;
            state_nxt   = ST_DATA;
          end else begin
            ld        = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          if (snd_cnt != '0) begin
            snd_cmd.pop = 1'b1;
            state_nxt   = ST_DATA;
          end else begin
            ld        = 1'b1;
            ld_ref    = flag_r;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_DATA: begin
        ld        = 1'b1;
        ld_ref    = flag_r;
        state_nxt = ST_IDLE;
        if (kind_r == KIND_GET) begin
          ld_getv = 1'b1;
          ld_b    = rcv_rdata;
        end else begin
          ld_txv = 1'b1;
          ld_b   = snd_rdata;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_vld_nxt = ld || (out_vld_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      idle_r <= in_tx_idle;
      flag_r <= (in_kind == KIND_PUT) && put_ref;
    end
    if (ld) begin
      txv_r  <= ld_txv;
      txw_r  <= ld_txv ? {1'b1, ld_b} : 9'h000;
      getv_r <= ld_getv;
      getb_r <= ld_getv ? ld_b : 8'h00;
      ref_r  <= ld_ref;
      drop_r <= ld_drop;
    end
  end

  butq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_send (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (snd_cmd),
    .count  (snd_cnt),
    .rd_data(snd_rdata)
  );

  butq_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_recv (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (rcv_cmd),
    .count  (rcv_cnt),
    .rd_data(rcv_rdata)
  );

  assign in_stall        = (state_r != ST_IDLE) || out_vld_r;
  assign out_valid       = out_vld_r;
  assign out_tx_valid    = txv_r;
  assign out_tx_word     = txw_r;
  assign out_get_valid   = getv_r;
  assign out_get_byte    = getb_r;
  assign out_put_refused = ref_r;
  assign out_rx_dropped  = drop_r;

endmodule
